// ----- design/thvt_pkg.sv -----
// ----------------------------------------------------------------------------
// thvt_pkg
// shared widths, constants and codes for the thermistor temperature converter
// ----------------------------------------------------------------------------
`default_nettype none

package thvt_pkg;

  localparam int RES_W   = 20;
  localparam int BETA_W  = 14;
  localparam int T0_W    = 10;
  localparam int VOLT_W  = 16;
  localparam int TEMP_W  = 16;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [RES_W-1:0]  SERIES_RST = 20'd10000;
  localparam logic [RES_W-1:0]  NOMRES_RST = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST   = 14'd3950;
  localparam logic [T0_W-1:0]   T0_RST     = 10'd298;

  // log2 datapath
  localparam int LOG_W   = 40;   // integer operand width
  localparam int K_W     = 6;    // exponent width
  localparam int MANT_W  = 32;   // mantissa in [1,2) with 31 fraction bits
  localparam int NSQ     = 24;   // squaring steps, one fraction bit each
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // restoring divider, one quotient bit per stage
  localparam int QBITS   = 17;
  localparam int REM_W   = 58;
  localparam int DIV_W   = 40;

  localparam logic [QBITS-1:0] KQ8_MAX    = 17'd102655; // 32767 + 273*256
  localparam logic [QBITS:0]   KELVIN_Q8  = 18'd69888;  // 273*256

  // pipeline positions
  localparam int ST_SQ0  = 3;
  localparam int ST_L    = ST_SQ0 + NSQ + 1;
  localparam int ST_LN   = ST_L + 1;
  localparam int ST_DD   = ST_LN + 1;
  localparam int ST_DIV0 = ST_DD + 1;
  localparam int ST_OUT  = ST_DIV0 + QBITS + 1;
  localparam int LAT     = ST_OUT + 1;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INV = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT = 2'd2;

  localparam logic [1:0] REG_SERIES = 2'd0;
  localparam logic [1:0] REG_NOMRES = 2'd1;
  localparam logic [1:0] REG_BETA   = 2'd2;
  localparam logic [1:0] REG_T0     = 2'd3;

endpackage

`default_nettype wire

// ----- design/thermistor_voltage_to_temp_top.sv -----
// ----------------------------------------------------------------------------
// thermistor_voltage_to_temp_top
// ntc thermistor beta-equation converter, divider voltages to q8.8 celsius
// ----------------------------------------------------------------------------
// One sample pair enters on any cycle that start is high; busy is tied low, so
// the block takes one beat every clock. The result beat appears on the out_
// ports for exactly one cycle with out_valid high; the receiver cannot stall.
// The pipeline is made up of the two log2 units (24 squaring stages, one
// 32x32 multiply each) and the restoring divider (17 stages, one quotient
// bit each). Registers are written over the apb port at byte addresses 0,
// 4, 8, 12 and must only change while no beat is in flight. status 1 means
// an invalid divider reading or a zero register (temperature 0); status 2
// means a saturated result.
`default_nettype none

module thermistor_voltage_to_temp_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [thvt_pkg::VOLT_W-1:0]         in_sample_voltage,
  input  wire  [thvt_pkg::VOLT_W-1:0]         in_supply_sense,
  output logic                                out_valid,
  output logic signed [thvt_pkg::TEMP_W-1:0]  out_temperature,
  output logic [thvt_pkg::STAT_W-1:0]         out_status,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [thvt_pkg::ADDR_W-1:0]         paddr,
  input  wire  [thvt_pkg::DATA_W-1:0]         pwdata,
  output logic [thvt_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import thvt_pkg::*;

  // ---------------------------------------------------------------- config
  logic [RES_W-1:0]  series_r, nomres_r;
  logic [BETA_W-1:0] beta_r;
  logic [T0_W-1:0]   t0_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RST;
      nomres_r <= NOMRES_RST;
      beta_r   <= BETA_RST;
      t0_r     <= T0_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SERIES: series_r <= pwdata[RES_W-1:0];
        REG_NOMRES: nomres_r <= pwdata[RES_W-1:0];
        REG_BETA:   beta_r   <= pwdata[BETA_W-1:0];
        REG_T0:     t0_r     <= pwdata[T0_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SERIES: prdata = DATA_W'(series_r);
      REG_NOMRES: prdata = DATA_W'(nomres_r);
      REG_BETA:   prdata = DATA_W'(beta_r);
      REG_T0:     prdata = DATA_W'(t0_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- control line
  // valid, invalid-reading and saturation flags travel with the data
  logic [LAT-1:0] vld_r;
  logic [ST_OUT-1:0] inv_r, sat_r;
  logic [ST_OUT-1:0] inv_nxt, sat_nxt;

  // ------------------------------------------------------------ datapath
  // stage 0: numerator and supply difference
  logic [LOG_W-1:0] num0_r, num0_nxt;
  logic [18:0]      diff0_r, diff0_nxt;
  logic [18:0]      supply;
  logic             inv0;
  // stage 1: denominator
  logic [LOG_W-1:0] num1_r, den1_r, den1_nxt;
  // stage 2: leading-one positions
  logic [LOG_W-1:0] num2_r, den2_r;
  logic [K_W-1:0]   kn2_r, kd2_r, kn2_nxt, kd2_nxt;
  // squaring stages, index 0 is the normalized mantissa
  logic [MANT_W-1:0] mn_r [0:NSQ];
  logic [MANT_W-1:0] md_r [0:NSQ];
  logic [NSQ-1:0]    fn_r [0:NSQ];
  logic [NSQ-1:0]    fd_r [0:NSQ];
  logic [K_W-1:0]    kn_r [0:NSQ];
  logic [K_W-1:0]    kd_r [0:NSQ];
  logic [MANT_W-1:0] mn_nxt [0:NSQ];
  logic [MANT_W-1:0] md_nxt [0:NSQ];
  logic [NSQ-1:0]    fn_nxt [0:NSQ];
  logic [NSQ-1:0]    fd_nxt [0:NSQ];
  // log difference, natural log, beta denominator
  logic signed [30:0] l_r, l_nxt;
  logic signed [31:0] lnq_r, lnq_nxt;
  logic signed [41:0] dd_r, dd_nxt;
  // divider
  logic [REM_W-1:0] rem_r [0:QBITS];
  logic [DIV_W-1:0] dv_r  [0:QBITS];
  logic [QBITS-1:0] q_r   [0:QBITS];
  logic [REM_W-1:0] rem_nxt [0:QBITS];
  logic [QBITS-1:0] q_nxt   [0:QBITS];
  // output
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [STAT_W-1:0]        stat_r, stat_nxt;

  always_comb begin
    logic [70:0]        shn, shd;
    logic [63:0]        pn, pd;
    logic [32:0]        tn, td;
    logic [30:0]        mag;
    logic [60:0]        lp;
    logic [30:0]        lr;
    logic signed [41:0] lnx, t0x, btx;
    logic [DIV_W-1:0]   dv;
    logic [REM_W-1:0]   nn, sub;
    logic [23:0]        t0b;
    logic signed [QBITS+1:0] cel;

    // stage 0
    supply    = {1'b0, in_supply_sense, 2'b00} + {2'b00, in_supply_sense, 1'b0};
    inv0      = (in_sample_voltage == '0) || (supply <= {3'b000, in_sample_voltage}) ||
                (series_r == '0) || (nomres_r == '0) || (beta_r == '0) || (t0_r == '0);
    num0_nxt  = LOG_W'(in_sample_voltage) * LOG_W'(series_r);
    diff0_nxt = supply - {3'b000, in_sample_voltage};
    // stage 1
    den1_nxt  = LOG_W'(diff0_r) * LOG_W'(nomres_r);
    // stage 2: leading-one search
    kn2_nxt = '0;
    kd2_nxt = '0;
    for (int b = 0; b < LOG_W; b++) begin
      if (num1_r[b]) kn2_nxt = K_W'(b);
      if (den1_r[b]) kd2_nxt = K_W'(b);
    end
    // stage 3: normalize to 31 fraction bits
    shn = {num2_r, 31'b0} >> kn2_r;
    shd = {den2_r, 31'b0} >> kd2_r;
    mn_nxt[0] = shn[MANT_W-1:0];
    md_nxt[0] = shd[MANT_W-1:0];
    fn_nxt[0] = '0;
    fd_nxt[0] = '0;
    // squaring steps, one log2 fraction bit each
    for (int i = 0; i < NSQ; i++) begin
      pn = 64'(mn_r[i]) * 64'(mn_r[i]);
      pd = 64'(md_r[i]) * 64'(md_r[i]);
      tn = pn[63:31];
      td = pd[63:31];
      mn_nxt[i+1] = tn[32] ? tn[32:1] : tn[31:0];
      md_nxt[i+1] = td[32] ? td[32:1] : td[31:0];
      fn_nxt[i+1] = {fn_r[i][NSQ-2:0], tn[32]};
      fd_nxt[i+1] = {fd_r[i][NSQ-2:0], td[32]};
    end
    // log2 ratio in q.24
    l_nxt = $signed({1'b0, kn_r[NSQ], fn_r[NSQ]}) - $signed({1'b0, kd_r[NSQ], fd_r[NSQ]});
    // scale by ln 2, round half away from zero
    mag = l_r[30] ? 31'(-l_r) : 31'(l_r);
    lp  = 61'(mag) * 61'(LN2_Q30) + 61'(1 << 29);
    lr  = lp[60:30];
    lnq_nxt = l_r[30] ? -$signed({1'b0, lr}) : $signed({1'b0, lr});
    // d = beta*2^24 + t0*ln
    lnx = lnq_r;
    t0x = $signed({32'b0, t0_r});
    btx = $signed({4'b0, beta_r, 24'b0});
    dd_nxt = btx + t0x * lnx;
    // divider load: n + d/2, saturate when the quotient needs more than 17 bits
    dv  = dd_r[DIV_W-1:0];
    t0b = 24'(t0_r) * 24'(beta_r);
    nn  = {2'b00, t0b, 32'b0} + REM_W'(dv >> 1);
    rem_nxt[0] = nn;
    q_nxt[0]   = '0;
    for (int j = 0; j < QBITS; j++) begin
      sub = REM_W'(dv_r[j]) << (QBITS - 1 - j);
      if (rem_r[j] >= sub) begin
        rem_nxt[j+1] = rem_r[j] - sub;
        q_nxt[j+1]   = {q_r[j][QBITS-2:0], 1'b1};
      end else begin
        rem_nxt[j+1] = rem_r[j];
        q_nxt[j+1]   = {q_r[j][QBITS-2:0], 1'b0};
      end
    end
    // flag line
    for (int s = 0; s < ST_OUT; s++) begin
      inv_nxt[s] = (s == 0) ? inv0 : inv_r[(s == 0) ? 0 : s-1];
      sat_nxt[s] = (s == 0) ? 1'b0 : sat_r[(s == 0) ? 0 : s-1];
    end
    sat_nxt[ST_DIV0] = sat_r[ST_DIV0-1] || (dd_r <= 0) || (nn >= (REM_W'(dv) << QBITS));
    // celsius and final status
    cel = $signed({2'b00, q_r[QBITS]}) - $signed({1'b0, KELVIN_Q8});
    if (inv_r[ST_OUT-1]) begin
      temp_nxt = '0;
      stat_nxt = STAT_INV;
    end else if (sat_r[ST_OUT-1] || (q_r[QBITS] > KQ8_MAX)) begin
      temp_nxt = 16'sh7FFF;
      stat_nxt = STAT_SAT;
    end else if (cel < -32768) begin
      temp_nxt = 16'sh8000;
      stat_nxt = STAT_SAT;
    end else begin
      temp_nxt = cel[TEMP_W-1:0];
      stat_nxt = STAT_OK;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inv_r   <= inv_nxt;
    sat_r   <= sat_nxt;
    num0_r  <= num0_nxt;
    diff0_r <= diff0_nxt;
    num1_r  <= num0_r;
    den1_r  <= den1_nxt;
    num2_r  <= num1_r;
    den2_r  <= den1_r;
    kn2_r   <= kn2_nxt;
    kd2_r   <= kd2_nxt;
    kn_r[0] <= kn2_r;
    kd_r[0] <= kd2_r;
    for (int i = 0; i <= NSQ; i++) begin
      mn_r[i] <= mn_nxt[i];
      md_r[i] <= md_nxt[i];
      fn_r[i] <= fn_nxt[i];
      fd_r[i] <= fd_nxt[i];
    end
    for (int i = 1; i <= NSQ; i++) begin
      kn_r[i] <= kn_r[i-1];
      kd_r[i] <= kd_r[i-1];
    end
    l_r   <= l_nxt;
    lnq_r <= lnq_nxt;
    dd_r  <= dd_nxt;
    dv_r[0] <= dd_r[DIV_W-1:0];
    for (int j = 0; j <= QBITS; j++) begin
      rem_r[j] <= rem_nxt[j];
      q_r[j]   <= q_nxt[j];
    end
    for (int j = 1; j <= QBITS; j++) begin
      dv_r[j] <= dv_r[j-1];
    end
    temp_r <= temp_nxt;
    stat_r <= stat_nxt;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_temperature = temp_r;
  assign out_status      = stat_r;

`ifndef SYNTHESIS
  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_INV) |-> (out_temperature == 16'sd0))
    else $error("invalid reading with nonzero temperature");
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_SAT) |->
    (out_temperature == 16'sh7FFF || out_temperature == 16'sh8000))
    else $error("saturated result not at a rail");
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_OUT-1] && !sat_r[ST_OUT-1]) |-> (rem_r[QBITS] < REM_W'(dv_r[QBITS])))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
